>>> rtl/iau_pkg.sv
`timescale 1ns / 1ps
// iau_pkg: shared constants, types and helper functions of the interval arithmetic unit
// no dependencies

package iau_pkg;

	localparam int W         = 64;
	localparam int WW        = 2 * W;
	localparam int HW        = W / 2;
	localparam int DIV_STEPS = W;

	// pipeline stage numbers
	localparam int MUL_STG   = 7;               // multiply result joins the side line here
	localparam int Q_STG     = DIV_STEPS + 2;   // signed quotients
	localparam int MM_STG    = DIV_STEPS + 3;   // pairwise min / max of quotients
	localparam int SIDE_LAST = MM_STG;          // last stage of the side line
	localparam int OUT_STG   = MM_STG + 1;      // output register

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [1:0] ST_DOVF = 2'd3;

	localparam logic [W-1:0] S64_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] S64_M1  = {W{1'b1}};

	// result and status that travel beside the arithmetic
	typedef struct packed {
		logic         dv_ok;   // divide with no trap: take the quotient path
		logic [1:0]   st;
		logic [W-1:0] rl;
		logic [W-1:0] rh;
	} side_t;

	typedef struct packed {
		logic [W-1:0] rem;
		logic [W-1:0] nq;      // numerator bits shift out, quotient bits shift in
	} div_lane_t;

	typedef struct packed {
		div_lane_t [3:0] lane;
		logic [W-1:0]    dl;
		logic [W-1:0]    dh;
		logic [3:0]      neg;
	} div_stage_t;

	function automatic div_lane_t div_step(input div_lane_t x, input logic [W-1:0] d);
		logic [W:0]  t;
		logic [W:0]  diff;
		div_lane_t   y;
		t    = {x.rem, x.nq[W-1]};
		diff = t - {1'b0, d};
		if (!diff[W]) begin
			y.rem = diff[W-1:0];
			y.nq  = {x.nq[W-2:0], 1'b1};
		end else begin
			y.rem = t[W-1:0];
			y.nq  = {x.nq[W-2:0], 1'b0};
		end
		return y;
	endfunction

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
	endfunction

endpackage

>>> rtl/iau_if.sv
`timescale 1ns / 1ps
// iau_req_if / iau_rsp_if: valid-ready channels of the interval arithmetic unit
// depends on iau_pkg

interface iau_req_if import iau_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   mode;
	logic [W-1:0] a_lo;
	logic [W-1:0] a_hi;
	logic [W-1:0] b_lo;
	logic [W-1:0] b_hi;
	modport source (output valid, mode, a_lo, a_hi, b_lo, b_hi, input ready);
	modport sink   (input valid, mode, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface iau_rsp_if import iau_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [W-1:0] res_lo;
	logic [W-1:0] res_hi;
	logic [1:0]   status;
	modport source (output valid, res_lo, res_hi, status, input ready);
	modport sink   (input valid, res_lo, res_hi, status, output ready);
endinterface

>>> rtl/interval_arithmetic_unit.sv
`timescale 1ns / 1ps
// interval_arithmetic_unit: pipelined add / sub / mul / div on signed 64-bit intervals
// depends on iau_pkg and the channel interfaces in iau_if.sv
//
//  channel  dir  word                                  handshake
//  req      in   mode, a_lo, a_hi, b_lo, b_hi          valid / ready
//  rsp      out  res_lo, res_hi, status                valid / ready
//
// one word enters per cycle while the pipe is not frozen; the req-to-rsp length is set
// by the 64-stage bit-per-stage restoring divider
// all stages advance together; a held rsp word freezes the whole pipe, and
// req.ready is high whenever the output register is empty or being taken
// reset clears only the valid bits of the stages and of the output register

module interval_arithmetic_unit import iau_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	iau_req_if.sink        req,
	iau_rsp_if.source      rsp
);

	logic en;
	logic rsp_vld_q;

	// valid bits of the side line, one per stage
	logic [SIDE_LAST:1] vld_s;
	side_t              side_s [SIDE_LAST:1];

	assign en        = !rsp_vld_q || rsp.ready;
	assign req.ready = en;

	// ---------------- stage 1: operands, add / sub, divide checks ----------------
	logic [W-1:0] al_s1, ah_s1, bl_s1, bh_s1;
	side_t        side_in;
	div_stage_t   dv_in;

	always_comb begin
		logic [W-1:0] l, h;
		logic         lo_bad, hi_bad;
		logic         divz, dovf;
		side_in = '0;
		if (req.mode == MODE_SUB) begin
			l      = req.a_lo - req.b_hi;
			h      = req.a_hi - req.b_lo;
			lo_bad = req.a_lo[W-1] && !req.b_hi[W-1] && !l[W-1];
			hi_bad = !req.a_hi[W-1] && req.b_lo[W-1] && h[W-1];
		end else begin
			l      = req.a_lo + req.b_lo;
			h      = req.a_hi + req.b_hi;
			lo_bad = req.a_lo[W-1] && req.b_lo[W-1] && !l[W-1];
			hi_bad = !req.a_hi[W-1] && !req.b_hi[W-1] && h[W-1];
		end
		// divisor spans zero or has a zero endpoint
		divz = ($signed(req.b_lo) <= 0 && $signed(req.b_hi) >= 0)
			|| req.b_lo == '0 || req.b_hi == '0;
		// most negative numerator over a divisor holding minus one
		dovf = req.a_lo == S64_MIN && $signed(req.b_lo) <= $signed(S64_M1)
			&& $signed(req.b_hi) >= $signed(S64_M1);
		case (req.mode)
			MODE_ADD, MODE_SUB: begin
				if (lo_bad || hi_bad) begin
					side_in.st = ST_OVF;
				end else begin
					side_in.rl = l;
					side_in.rh = h;
				end
			end
			MODE_DIV: begin
				if (divz) begin
					side_in.st = ST_DIVZ;
				end else if (dovf) begin
					side_in.st = ST_DOVF;
				end else begin
					side_in.dv_ok = 1'b1;
				end
			end
			default: begin
				// multiply result is filled in later
			end
		endcase

		// divider prep: magnitudes and quotient signs, lanes al/bl al/bh ah/bl ah/bh
		dv_in.dl = mag(req.b_lo);
		dv_in.dh = mag(req.b_hi);
		dv_in.lane[0] = '{rem: '0, nq: mag(req.a_lo)};
		dv_in.lane[1] = '{rem: '0, nq: mag(req.a_lo)};
		dv_in.lane[2] = '{rem: '0, nq: mag(req.a_hi)};
		dv_in.lane[3] = '{rem: '0, nq: mag(req.a_hi)};
		dv_in.neg[0] = req.a_lo[W-1] ^ req.b_lo[W-1];
		dv_in.neg[1] = req.a_lo[W-1] ^ req.b_hi[W-1];
		dv_in.neg[2] = req.a_hi[W-1] ^ req.b_lo[W-1];
		dv_in.neg[3] = req.a_hi[W-1] ^ req.b_hi[W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			al_s1 <= req.a_lo;
			ah_s1 <= req.a_hi;
			bl_s1 <= req.b_lo;
			bh_s1 <= req.b_hi;
		end
	end

	// ---------------- multiply: stages 2 to 6 ----------------
	logic [W-1:0]  ma_s2 [4];
	logic [W-1:0]  mb_s2 [4];
	logic [W-1:0]  pp_s2 [4][4];   // a0b0, a0b1, a1b0, a1b1
	logic [W-1:0]  ma_s3 [4];
	logic [W-1:0]  mb_s3 [4];
	logic [WW-1:0] u_s3  [4];
	logic [WW-1:0] p_s4  [4];
	logic [WW-1:0] mn01_s5, mx01_s5, mn23_s5, mx23_s5;
	logic [WW-1:0] mn_s6, mx_s6;
	logic [W-1:0]  ma_op [4];
	logic [W-1:0]  mb_op [4];

	assign ma_op[0] = al_s1;
	assign ma_op[1] = al_s1;
	assign ma_op[2] = ah_s1;
	assign ma_op[3] = ah_s1;
	assign mb_op[0] = bl_s1;
	assign mb_op[1] = bh_s1;
	assign mb_op[2] = bl_s1;
	assign mb_op[3] = bh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				// 32x32 partial products
				ma_s2[i]    <= ma_op[i];
				mb_s2[i]    <= mb_op[i];
				pp_s2[i][0] <= W'(ma_op[i][HW-1:0]) * W'(mb_op[i][HW-1:0]);
				pp_s2[i][1] <= W'(ma_op[i][HW-1:0]) * W'(mb_op[i][W-1:HW]);
				pp_s2[i][2] <= W'(ma_op[i][W-1:HW]) * W'(mb_op[i][HW-1:0]);
				pp_s2[i][3] <= W'(ma_op[i][W-1:HW]) * W'(mb_op[i][W-1:HW]);
				// unsigned 128-bit product
				ma_s3[i] <= ma_s2[i];
				mb_s3[i] <= mb_s2[i];
				u_s3[i]  <= {{W{1'b0}}, pp_s2[i][0]}
					+ {{HW{1'b0}}, pp_s2[i][1], {HW{1'b0}}}
					+ {{HW{1'b0}}, pp_s2[i][2], {HW{1'b0}}}
					+ {pp_s2[i][3], {W{1'b0}}};
				// signed correction of the upper half
				p_s4[i] <= {u_s3[i][WW-1:W]
					- (ma_s3[i][W-1] ? mb_s3[i] : {W{1'b0}})
					- (mb_s3[i][W-1] ? ma_s3[i] : {W{1'b0}}), u_s3[i][W-1:0]};
			end
			mn01_s5 <= ($signed(p_s4[1]) < $signed(p_s4[0])) ? p_s4[1] : p_s4[0];
			mx01_s5 <= ($signed(p_s4[0]) < $signed(p_s4[1])) ? p_s4[1] : p_s4[0];
			mn23_s5 <= ($signed(p_s4[3]) < $signed(p_s4[2])) ? p_s4[3] : p_s4[2];
			mx23_s5 <= ($signed(p_s4[2]) < $signed(p_s4[3])) ? p_s4[3] : p_s4[2];
			mn_s6   <= ($signed(mn23_s5) < $signed(mn01_s5)) ? mn23_s5 : mn01_s5;
			mx_s6   <= ($signed(mx01_s5) < $signed(mx23_s5)) ? mx23_s5 : mx01_s5;
		end
	end

	side_t mul_side;
	always_comb begin
		logic mn_fits, mx_fits;
		mn_fits  = mn_s6[WW-1:W] == {W{mn_s6[W-1]}};
		mx_fits  = mx_s6[WW-1:W] == {W{mx_s6[W-1]}};
		mul_side = '0;
		if ((!mn_fits && mn_s6[WW-1]) || (!mx_fits && !mx_s6[WW-1])) begin
			mul_side.st = ST_OVF;
		end else begin
			mul_side.rl = mn_s6[W-1:0];
			mul_side.rh = mx_s6[W-1:0];
		end
	end

	// mode rides along until the multiply result is merged
	logic [1:0] mode_s [MUL_STG-1:1];

	// ---------------- side line ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SIDE_LAST-1:1], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			mode_s[1] <= req.mode;
			for (int k = 2; k < MUL_STG; k++) begin
				mode_s[k] <= mode_s[k-1];
			end
			for (int k = 2; k <= SIDE_LAST; k++) begin
				if (k == MUL_STG && mode_s[MUL_STG-1] == MODE_MUL) begin
					side_s[k] <= mul_side;
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// ---------------- divide: one quotient bit per stage ----------------
	div_stage_t dv_s [DIV_STEPS:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dv_in;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_s[k].dl  <= dv_s[k-1].dl;
				dv_s[k].dh  <= dv_s[k-1].dh;
				dv_s[k].neg <= dv_s[k-1].neg;
				for (int i = 0; i < 4; i++) begin
					dv_s[k].lane[i] <= div_step(dv_s[k-1].lane[i],
						i[0] ? dv_s[k-1].dh : dv_s[k-1].dl);
				end
			end
		end
	end

	logic [W-1:0] q_s   [4];
	logic [W-1:0] qmn01_s, qmx01_s, qmn23_s, qmx23_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				// the most negative over minus one wraps back to itself here
				q_s[i] <= dv_s[DIV_STEPS].neg[i] ? (~dv_s[DIV_STEPS].lane[i].nq
					+ {{(W-1){1'b0}}, 1'b1}) : dv_s[DIV_STEPS].lane[i].nq;
			end
			qmn01_s <= ($signed(q_s[1]) < $signed(q_s[0])) ? q_s[1] : q_s[0];
			qmx01_s <= ($signed(q_s[0]) < $signed(q_s[1])) ? q_s[1] : q_s[0];
			qmn23_s <= ($signed(q_s[3]) < $signed(q_s[2])) ? q_s[3] : q_s[2];
			qmx23_s <= ($signed(q_s[2]) < $signed(q_s[3])) ? q_s[3] : q_s[2];
		end
	end

	// ---------------- output register ----------------
	logic [W-1:0] res_lo_q, res_hi_q;
	logic [1:0]   status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (en) begin
			rsp_vld_q <= vld_s[SIDE_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= side_s[SIDE_LAST].st;
			if (side_s[SIDE_LAST].dv_ok) begin
				res_lo_q <= ($signed(qmn23_s) < $signed(qmn01_s)) ? qmn23_s : qmn01_s;
				res_hi_q <= ($signed(qmx01_s) < $signed(qmx23_s)) ? qmx23_s : qmx01_s;
			end else begin
				res_lo_q <= side_s[SIDE_LAST].rl;
				res_hi_q <= side_s[SIDE_LAST].rh;
			end
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.res_lo = res_lo_q;
	assign rsp.res_hi = res_hi_q;
	assign rsp.status = status_q;

	// ---------------- checks ----------------
	// a held output freezes every stage
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipe moved while output held");

	// any trap gives an all-zero interval
	a_trap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.res_lo == '0 && rsp.res_hi == '0)
		else $error("trap with nonzero bounds");

	// last side stage reaches the output when the pipe moves
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[SIDE_LAST] |=> rsp_vld_q)
		else $error("word lost before output register");

	// a quotient result never carries a trap status
	a_div_ok: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SIDE_LAST] && side_s[SIDE_LAST].dv_ok |-> side_s[SIDE_LAST].st == ST_OK)
		else $error("divide path with trap status");

endmodule
